### hdl/page_frame_allocator_unit_defines.svh
// Shared assertion macros for the frame allocator.
`ifndef PAGE_FRAME_ALLOCATOR_UNIT_DEFINES_SVH
`define PAGE_FRAME_ALLOCATOR_UNIT_DEFINES_SVH

// Condition holds at every edge outside reset.
`define PFA_ASSERT_HOLD(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("frame allocator invariant violated");

// Consequent holds in the cycle after the antecedent.
`define PFA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame allocator step check failed");

`endif

### hdl/pfa_pkg.sv
package pfa_pkg;

   localparam int SEG_DEPTH      = 16;
   localparam int RESERVED_DEPTH = 16;
   localparam int USED_DEPTH     = 1024;

   localparam int ADDR_W      = 48;
   localparam int FRAME_SHIFT = 12;
   localparam int FN_W        = ADDR_W - FRAME_SHIFT;
   localparam int TYPE_W      = 2;
   localparam int STATUS_W    = 3;

   localparam logic [TYPE_W-1:0] REQ_ALLOC    = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_FREE     = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_SEGMENT  = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_RESERVED = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_OOM       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_USED_FULL = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd3;
   localparam logic [STATUS_W-1:0] ST_REJECT    = 3'd4;

   typedef enum logic [1:0] {
      FRAME_NONE  = 2'd0,
      FRAME_POP   = 2'd1,
      FRAME_GRANT = 2'd2
   } frame_sel_type;

   typedef struct packed {
      logic                take;
      logic                res_set;
      logic [STATUS_W-1:0] res_status;
      frame_sel_type       res_frame;
      logic                seg_load;
      logic                rsv_load;
      logic                pop_commit;
      logic                seg_next;
      logic                seg_latch;
      logic                rsv_start;
      logic                rsv_step;
      logic                pos_update;
      logic                grant;
      logic                free_start;
      logic                free_step;
      logic                hit_record;
      logic                rd_last;
      logic                move_commit;
      logic                rsp_load;
   } cmd_type;

   typedef struct packed {
      logic [TYPE_W-1:0] req_type;
      logic              used_full;
      logic              used_empty;
      logic              rec_empty;
      logic              seg_full;
      logic              beg_zero;
      logic              rsv_full;
      logic              rsv_empty;
      logic              unaligned;
      logic              seg_done;
      logic              overrun;
      logic              rsv_last;
      logic              any_hit;
      logic              e_below;
      logic              free_match;
      logic              used_idx_last;
   } sts_type;

endpackage

### hdl/pfa_ram.sv
module pfa_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/pfa_ctrl.sv
module pfa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  pfa_pkg::sts_type sts,
   output pfa_pkg::cmd_type cmd
);

   typedef enum logic [15:0] {
      S_IDLE      = 16'h0001,
      S_DISPATCH  = 16'h0002,
      S_POP_WAIT  = 16'h0004,
      S_POP_WR    = 16'h0008,
      S_SEG_CHK   = 16'h0010,
      S_SEG_LATCH = 16'h0020,
      S_SEG_FIT   = 16'h0040,
      S_RSV_WAIT  = 16'h0080,
      S_RSV_EV    = 16'h0100,
      S_RSV_DONE  = 16'h0200,
      S_GRANT     = 16'h0400,
      S_FREE_WAIT = 16'h0800,
      S_FREE_EV   = 16'h1000,
      S_MOVE_WAIT = 16'h2000,
      S_MOVE_WR   = 16'h4000,
      S_FINISH    = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = reset | (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_FINISH;
            case (sts.req_type)
               pfa_pkg::REQ_ALLOC: begin
                  if (sts.used_full) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = pfa_pkg::ST_USED_FULL;
                  end else if (!sts.rec_empty) begin
                     state_in = S_POP_WAIT;
                  end else begin
                     state_in = S_SEG_CHK;
                  end
               end
               pfa_pkg::REQ_FREE: begin
                  if (sts.unaligned || sts.used_empty) begin
                     cmd.res_set    = 1'b1;
                     cmd.res_status = pfa_pkg::ST_NOT_ALLOC;
                  end else begin
                     cmd.free_start = 1'b1;
                     state_in       = S_FREE_WAIT;
                  end
               end
               pfa_pkg::REQ_SEGMENT: begin
                  cmd.res_set = 1'b1;
                  if (sts.seg_full || sts.beg_zero) begin
                     cmd.res_status = pfa_pkg::ST_REJECT;
                  end else begin
                     cmd.res_status = pfa_pkg::ST_OK;
                     cmd.seg_load   = 1'b1;
                  end
               end
               default: begin
                  cmd.res_set = 1'b1;
                  if (sts.rsv_full) begin
                     cmd.res_status = pfa_pkg::ST_REJECT;
                  end else begin
                     cmd.res_status = pfa_pkg::ST_OK;
                     cmd.rsv_load   = 1'b1;
                  end
               end
            endcase
         end
         S_POP_WAIT: begin
            state_in = S_POP_WR;
         end
         S_POP_WR: begin
            cmd.pop_commit = 1'b1;
            cmd.res_set    = 1'b1;
            cmd.res_status = pfa_pkg::ST_OK;
            cmd.res_frame  = pfa_pkg::FRAME_POP;
            state_in       = S_FINISH;
         end
         S_SEG_CHK: begin
            if (sts.seg_done) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = pfa_pkg::ST_OOM;
               state_in       = S_FINISH;
            end else begin
               state_in = S_SEG_LATCH;
            end
         end
         S_SEG_LATCH: begin
            cmd.seg_latch = 1'b1;
            state_in      = S_SEG_FIT;
         end
         S_SEG_FIT: begin
            if (sts.overrun) begin
               cmd.seg_next = 1'b1;
               state_in     = S_SEG_CHK;
            end else if (sts.rsv_empty) begin
               state_in = S_GRANT;
            end else begin
               cmd.rsv_start = 1'b1;
               state_in      = S_RSV_WAIT;
            end
         end
         S_RSV_WAIT: begin
            state_in = S_RSV_EV;
         end
         S_RSV_EV: begin
            cmd.rsv_step = 1'b1;
            state_in     = sts.rsv_last ? S_RSV_DONE : S_RSV_WAIT;
         end
         S_RSV_DONE: begin
            if (!sts.any_hit) begin
               state_in = S_GRANT;
            end else begin
               // skip past the region, or give up on this segment
               cmd.pos_update = sts.e_below;
               cmd.seg_next   = !sts.e_below;
               state_in       = S_SEG_CHK;
            end
         end
         S_GRANT: begin
            cmd.grant      = 1'b1;
            cmd.res_set    = 1'b1;
            cmd.res_status = pfa_pkg::ST_OK;
            cmd.res_frame  = pfa_pkg::FRAME_GRANT;
            state_in       = S_FINISH;
         end
         S_FREE_WAIT: begin
            state_in = S_FREE_EV;
         end
         S_FREE_EV: begin
            if (sts.free_match) begin
               cmd.hit_record = 1'b1;
               state_in       = S_MOVE_WAIT;
            end else if (sts.used_idx_last) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = pfa_pkg::ST_NOT_ALLOC;
               state_in       = S_FINISH;
            end else begin
               cmd.free_step = 1'b1;
               state_in      = S_FREE_WAIT;
            end
         end
         S_MOVE_WAIT: begin
            cmd.rd_last = 1'b1;
            state_in    = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            cmd.rd_last     = 1'b1;
            cmd.move_commit = 1'b1;
            cmd.res_set     = 1'b1;
            cmd.res_status  = pfa_pkg::ST_OK;
            state_in        = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### hdl/pfa_dp.sv
`include "page_frame_allocator_unit_defines.svh"

module pfa_dp #(
   parameter int SEG_DEPTH      = pfa_pkg::SEG_DEPTH,
   parameter int RESERVED_DEPTH = pfa_pkg::RESERVED_DEPTH,
   parameter int USED_DEPTH     = pfa_pkg::USED_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pfa_pkg::TYPE_W-1:0]    req_type,
   input  logic [pfa_pkg::ADDR_W-1:0]    req_addr_begin,
   input  logic [pfa_pkg::ADDR_W-1:0]    req_addr_end,
   output logic [pfa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [pfa_pkg::ADDR_W-1:0]    rsp_frame_addr,
   input  pfa_pkg::cmd_type              cmd,
   output pfa_pkg::sts_type              sts
);

   localparam int AW   = pfa_pkg::ADDR_W;
   localparam int CW   = AW + 1;
   localparam int FS   = pfa_pkg::FRAME_SHIFT;
   localparam int FNW  = pfa_pkg::FN_W;
   localparam int SCW  = $clog2(SEG_DEPTH + 1);
   localparam int SAW  = (SEG_DEPTH > 1) ? $clog2(SEG_DEPTH) : 1;
   localparam int RCW  = $clog2(RESERVED_DEPTH + 1);
   localparam int RAW  = (RESERVED_DEPTH > 1) ? $clog2(RESERVED_DEPTH) : 1;
   localparam int UCW  = $clog2(USED_DEPTH + 1);
   localparam int UAW  = (USED_DEPTH > 1) ? $clog2(USED_DEPTH) : 1;
   localparam logic [CW-1:0] FRAME_BYTES = CW'(1) << FS;
   localparam logic [CW-1:0] FRAME_MASK  = FRAME_BYTES - CW'(1);

   logic [pfa_pkg::TYPE_W-1:0] type_ff;
   logic [AW-1:0]  beg_ff, end_ff;
   logic [SCW-1:0] seg_count_ff, cur_seg_ff;
   logic [RCW-1:0] rsv_count_ff, rsv_idx_ff;
   logic [UCW-1:0] rec_count_ff, used_count_ff, used_idx_ff;
   logic [UAW-1:0] hit_slot_ff;
   logic [CW-1:0]  cand_ff;
   logic [AW-1:0]  segend_ff;
   logic           hit1_ff, hit2_ff;
   logic [AW-1:0]  e1_ff, e2_ff;
   logic [pfa_pkg::STATUS_W-1:0] pend_status_ff, rsp_status_ff;
   logic [AW-1:0]  pend_frame_ff, rsp_frame_ff;

   logic [2*AW-1:0] seg_rd, seg_wdata, rsv_rd;
   logic [SAW-1:0]  seg_waddr;
   logic            seg_we;
   logic [FNW-1:0]  rec_rd, used_rd, used_wdata;
   logic [UAW-1:0]  used_waddr, used_raddr, rec_top, used_last;
   logic            used_we;
   logic [CW-1:0]   cand_next, c2, rb, re;
   logic            h1, h2;
   logic [AW-1:0]   esel;
   logic [AW-1:0]   pend_frame_in;
   logic [UCW-1:0]  used_count_m1, rec_count_m1;

   assign c2            = cand_ff + FRAME_BYTES;
   assign rb            = {1'b0, rsv_rd[2*AW-1:AW]};
   assign re            = {1'b0, rsv_rd[AW-1:0]};
   assign h1            = (cand_ff >= rb) && (cand_ff <= re);
   assign h2            = (c2 >= rb) && (c2 <= re);
   assign esel          = hit2_ff ? e2_ff : e1_ff;
   assign cand_next     = ({1'b0, seg_rd[AW-1:0]} + FRAME_MASK) & ~FRAME_MASK;
   assign used_count_m1 = used_count_ff - UCW'(1);
   assign rec_count_m1  = rec_count_ff - UCW'(1);
   assign used_last     = used_count_m1[UAW-1:0];
   assign rec_top       = rec_count_m1[UAW-1:0];
   assign used_raddr    = cmd.rd_last ? used_last : used_idx_ff[UAW-1:0];

   // segment table: {end, position}
   always_comb begin
      seg_we    = cmd.seg_load | cmd.pos_update | cmd.grant;
      seg_waddr = cur_seg_ff[SAW-1:0];
      seg_wdata = {segend_ff, c2[AW-1:0]};
      if (cmd.seg_load) begin
         seg_waddr = seg_count_ff[SAW-1:0];
         seg_wdata = {end_ff, beg_ff};
      end else if (cmd.pos_update) begin
         seg_wdata = {segend_ff, esel + AW'(1)};
      end
   end

   always_comb begin
      used_we    = cmd.grant | cmd.pop_commit | cmd.move_commit;
      used_waddr = used_count_ff[UAW-1:0];
      used_wdata = cand_ff[AW-1:FS];
      if (cmd.pop_commit) begin
         used_wdata = rec_rd;
      end else if (cmd.move_commit) begin
         used_waddr = hit_slot_ff;
         used_wdata = used_rd;
      end
   end

   always_comb begin
      case (cmd.res_frame)
         pfa_pkg::FRAME_POP:   pend_frame_in = {rec_rd, {FS{1'b0}}};
         pfa_pkg::FRAME_GRANT: pend_frame_in = cand_ff[AW-1:0];
         default:              pend_frame_in = '0;
      endcase
   end

   pfa_ram #(.WIDTH(2*AW), .DEPTH(SEG_DEPTH)) u_seg_ram (
      .clock   (clock),
      .wr_en   (seg_we),
      .wr_addr (seg_waddr),
      .wr_data (seg_wdata),
      .rd_addr (cur_seg_ff[SAW-1:0]),
      .rd_data (seg_rd)
   );

   pfa_ram #(.WIDTH(2*AW), .DEPTH(RESERVED_DEPTH)) u_rsv_ram (
      .clock   (clock),
      .wr_en   (cmd.rsv_load),
      .wr_addr (rsv_count_ff[RAW-1:0]),
      .wr_data ({beg_ff, end_ff}),
      .rd_addr (rsv_idx_ff[RAW-1:0]),
      .rd_data (rsv_rd)
   );

   pfa_ram #(.WIDTH(FNW), .DEPTH(USED_DEPTH)) u_rec_ram (
      .clock   (clock),
      .wr_en   (cmd.move_commit),
      .wr_addr (rec_count_ff[UAW-1:0]),
      .wr_data (beg_ff[AW-1:FS]),
      .rd_addr (rec_top),
      .rd_data (rec_rd)
   );

   // used table stays packed: entries below used_count are live
   pfa_ram #(.WIDTH(FNW), .DEPTH(USED_DEPTH)) u_used_ram (
      .clock   (clock),
      .wr_en   (used_we),
      .wr_addr (used_waddr),
      .wr_data (used_wdata),
      .rd_addr (used_raddr),
      .rd_data (used_rd)
   );

   always_comb begin
      sts.req_type      = type_ff;
      sts.used_full     = (used_count_ff == UCW'(USED_DEPTH));
      sts.used_empty    = (used_count_ff == '0);
      sts.rec_empty     = (rec_count_ff == '0);
      sts.seg_full      = (seg_count_ff == SCW'(SEG_DEPTH));
      sts.beg_zero      = (beg_ff == '0);
      sts.rsv_full      = (rsv_count_ff == RCW'(RESERVED_DEPTH));
      sts.rsv_empty     = (rsv_count_ff == '0);
      sts.unaligned     = (beg_ff[FS-1:0] != '0);
      sts.seg_done      = (cur_seg_ff >= seg_count_ff);
      sts.overrun       = (c2 > {1'b0, segend_ff});
      sts.rsv_last      = (rsv_idx_ff == rsv_count_ff - RCW'(1));
      sts.any_hit       = hit1_ff | hit2_ff;
      sts.e_below       = (esel < segend_ff);
      sts.free_match    = (used_rd == beg_ff[AW-1:FS]);
      sts.used_idx_last = (used_idx_ff == used_count_m1);
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         type_ff <= req_type;
         beg_ff  <= req_addr_begin;
         end_ff  <= req_addr_end;
      end
      if (cmd.seg_latch) begin
         cand_ff   <= cand_next;
         segend_ff <= seg_rd[2*AW-1:AW];
      end
      if (cmd.rsv_start) begin
         hit1_ff <= 1'b0;
         hit2_ff <= 1'b0;
      end else if (cmd.rsv_step) begin
         // keep the first match in table order
         if (h1 && !hit1_ff) begin
            hit1_ff <= 1'b1;
            e1_ff   <= rsv_rd[AW-1:0];
         end
         if (h2 && !hit2_ff) begin
            hit2_ff <= 1'b1;
            e2_ff   <= rsv_rd[AW-1:0];
         end
      end
      if (cmd.hit_record) begin
         hit_slot_ff <= used_idx_ff[UAW-1:0];
      end
      if (cmd.res_set) begin
         pend_status_ff <= cmd.res_status;
         pend_frame_ff  <= pend_frame_in;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= pend_status_ff;
         rsp_frame_ff  <= pend_frame_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff  <= '0;
         cur_seg_ff    <= '0;
         rsv_count_ff  <= '0;
         rsv_idx_ff    <= '0;
         rec_count_ff  <= '0;
         used_count_ff <= '0;
         used_idx_ff   <= '0;
      end else begin
         if (cmd.seg_load) seg_count_ff <= seg_count_ff + SCW'(1);
         if (cmd.seg_next) cur_seg_ff <= cur_seg_ff + SCW'(1);
         if (cmd.rsv_load) rsv_count_ff <= rsv_count_ff + RCW'(1);
         if (cmd.rsv_start) begin
            rsv_idx_ff <= '0;
         end else if (cmd.rsv_step) begin
            rsv_idx_ff <= rsv_idx_ff + RCW'(1);
         end
         if (cmd.free_start) begin
            used_idx_ff <= '0;
         end else if (cmd.free_step) begin
            used_idx_ff <= used_idx_ff + UCW'(1);
         end
         if (cmd.grant) begin
            used_count_ff <= used_count_ff + UCW'(1);
         end else if (cmd.pop_commit) begin
            used_count_ff <= used_count_ff + UCW'(1);
            rec_count_ff  <= rec_count_m1;
         end else if (cmd.move_commit) begin
            used_count_ff <= used_count_m1;
            rec_count_ff  <= rec_count_ff + UCW'(1);
         end
      end
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_frame_addr = rsp_frame_ff;

   `PFA_ASSERT_HOLD(a_seg_order, cur_seg_ff <= seg_count_ff)
   `PFA_ASSERT_HOLD(a_frame_budget,
      ((UCW+1)'(rec_count_ff) + (UCW+1)'(used_count_ff)) <= (UCW+1)'(USED_DEPTH))
   `PFA_ASSERT_NEXT(a_grant_records, cmd.grant,
      used_count_ff == $past(used_count_ff) + UCW'(1))
   `PFA_ASSERT_NEXT(a_free_pushes, cmd.move_commit,
      rec_count_ff == $past(rec_count_ff) + UCW'(1))

endmodule

### hdl/page_frame_allocator_unit.sv
// Channel   Handshake            Beat contents
// req       req_valid/req_stall  req_type, req_addr_begin, req_addr_end
// rsp       rsp_valid/rsp_stall  rsp_status, rsp_frame_addr
//
// One request at a time; a load or rejected request passes dispatch, then finish.
// Free scans the used table entry by entry, then moves the last entry into the freed slot
// and pushes the frame. Fresh allocate steps through the segments and, for each candidate,
// through every reserved region, via the single read port of each table RAM.
// Reset is synchronous and clears only counters and control; no clearing pass.
// A stalled result is held in the output register; the next beat is taken after it moves.
module page_frame_allocator_unit #(
   parameter int SEG_DEPTH      = pfa_pkg::SEG_DEPTH,
   parameter int RESERVED_DEPTH = pfa_pkg::RESERVED_DEPTH,
   parameter int USED_DEPTH     = pfa_pkg::USED_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pfa_pkg::TYPE_W-1:0]    req_type,
   input  logic [pfa_pkg::ADDR_W-1:0]    req_addr_begin,
   input  logic [pfa_pkg::ADDR_W-1:0]    req_addr_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [pfa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [pfa_pkg::ADDR_W-1:0]    rsp_frame_addr
);

   pfa_pkg::cmd_type cmd;
   pfa_pkg::sts_type sts;

   pfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   pfa_dp #(
      .SEG_DEPTH      (SEG_DEPTH),
      .RESERVED_DEPTH (RESERVED_DEPTH),
      .USED_DEPTH     (USED_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_type       (req_type),
      .req_addr_begin (req_addr_begin),
      .req_addr_end   (req_addr_end),
      .rsp_status     (rsp_status),
      .rsp_frame_addr (rsp_frame_addr),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule
